// File: design/ipt_pkg.sv
// Shared constants for the inverse Park transform datapath.
package ipt_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 1024;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned PHASE_W = 18;
  localparam int unsigned ENTRY_W = 15;
  localparam int unsigned PROD_W  = 2 * COMP_W;
  localparam int unsigned DIFF_W  = PROD_W + 1;
  localparam int unsigned FRAC_SH = 15;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned ENTRY_MAX   = 64'd32767;

  localparam logic signed [DIFF_W-1:0] ROUND_HALF = DIFF_W'(16384);

endpackage

// File: design/ipt_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module ipt_sine_rom #(
  parameter int unsigned DEPTH = ipt_pkg::SINE_DEPTH_DEF,
  localparam int unsigned AddrW = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [AddrW-1:0]              sin_addr_i,
  input  logic [AddrW-1:0]              cos_addr_i,
  output logic [ipt_pkg::ENTRY_W-1:0]   sin_data_o,
  output logic [ipt_pkg::ENTRY_W-1:0]   cos_data_o
);

  localparam longint unsigned TaylorDiv [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Taylor series in Q30, rounded to Q0.15, full scale clipped
  function automatic logic [ipt_pkg::ENTRY_W-1:0] sine_entry(input logic [31:0] idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    x    = (ipt_pkg::HALF_PI_Q30 * 64'(idx)) / DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / TaylorDiv[n-1];
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32768 + (ipt_pkg::ONE_Q30 >> 1)) >> 30;
    if (v > ipt_pkg::ENTRY_MAX) begin
      v = ipt_pkg::ENTRY_MAX;
    end
    return ipt_pkg::ENTRY_W'(v);
  endfunction

  logic [ipt_pkg::ENTRY_W-1:0] rom [DEPTH+1];

  for (genvar i = 0; i <= DEPTH; i++) begin : g_rom
    assign rom[i] = sine_entry(32'(i));
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sin_data_o <= rom[sin_addr_i];
      cos_data_o <= rom[cos_addr_i];
    end
  end

endmodule

// File: design/inverse_park_transform.sv
// Inverse Park transform, dq0 to abc, five-stage pipeline.
//
//  channel | direction | handshake               | payload
//  in      | sink      | in_valid_i / in_stall_o  | angle, direct, quadrature, zero part
//  out     | source    | out_valid_o / out_stall_i| phase a, b, c
//
// One transaction per cycle sustained while out_stall_i stays low.
// Stages: phase angles, ROM addresses, ROM read, two multipliers per phase, round and sum.
// Throughput is set by the ROM ports: each phase has its own two-port ROM copy.
// Reset clears only the stage valid bits; no clearing pass.
// A stall holds each full stage up to the first bubble; empty stages keep filling, so bubbles close up.
module inverse_park_transform #(
  parameter int unsigned SINE_TABLE_DEPTH = ipt_pkg::SINE_DEPTH_DEF,
  parameter int unsigned ANGLE_BITS       = ipt_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ipt_pkg::ANGLE_W-1:0]         angle_i,
  input  logic signed [ipt_pkg::COMP_W-1:0]   direct_part_i,
  input  logic signed [ipt_pkg::COMP_W-1:0]   quadrature_part_i,
  input  logic signed [ipt_pkg::COMP_W-1:0]   zero_part_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ipt_pkg::PHASE_W-1:0]  phase_a_o,
  output logic signed [ipt_pkg::PHASE_W-1:0]  phase_b_o,
  output logic signed [ipt_pkg::PHASE_W-1:0]  phase_c_o
);

  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PosW  = ANGLE_BITS - 2;
  localparam int unsigned MulW  = PosW + AddrW;
  localparam longint unsigned ThirdTurn = ((64'd1 << ANGLE_BITS) + 64'd1) / 3;
  localparam logic [ANGLE_BITS-1:0] Third   = ANGLE_BITS'(ThirdTurn);
  localparam logic [ANGLE_BITS-1:0] Quarter = ANGLE_BITS'(64'd1 << PosW);
  localparam logic [AddrW-1:0]      TopIdx  = AddrW'(SINE_TABLE_DEPTH);
  localparam int unsigned CW = ipt_pkg::COMP_W;
  localparam int unsigned PW = ipt_pkg::PROD_W;
  localparam int unsigned DW = ipt_pkg::DIFF_W;
  localparam int unsigned OW = ipt_pkg::PHASE_W;

  function automatic logic [AddrW-1:0] rom_addr(input logic [ANGLE_BITS-1:0] t);
    logic [MulW-1:0]  prod;
    logic [AddrW-1:0] idx;
    prod = MulW'(t[PosW-1:0]) * MulW'(SINE_TABLE_DEPTH);
    idx  = AddrW'(prod >> PosW);
    return t[ANGLE_BITS-2] ? TopIdx - idx : idx;
  endfunction

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o  = !en1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: phase angles
  logic [ANGLE_BITS-1:0]   ang_d;
  logic [ANGLE_BITS-1:0]   ang_q [3];
  logic signed [CW-1:0]    d1_q, q1_q, z1_q;

  assign ang_d = ANGLE_BITS'(angle_i);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ang_q[0] <= ang_d;
      ang_q[1] <= ang_d - Third;
      ang_q[2] <= ang_d + Third;
      d1_q     <= direct_part_i;
      q1_q     <= quadrature_part_i;
      z1_q     <= zero_part_i;
    end
  end

  // stage 2: ROM addresses and sign bits
  logic [AddrW-1:0]      sin_addr_q [3];
  logic [AddrW-1:0]      cos_addr_q [3];
  logic [2:0]            sin_neg_q, cos_neg_q;
  logic signed [CW-1:0]  d2_q, q2_q, z2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int p = 0; p < 3; p++) begin
        sin_addr_q[p] <= rom_addr(ang_q[p]);
        cos_addr_q[p] <= rom_addr(ang_q[p] + Quarter);
        sin_neg_q[p]  <= ang_q[p][ANGLE_BITS-1];
        cos_neg_q[p]  <= ang_q[p][ANGLE_BITS-1] ^
                         (ang_q[p][ANGLE_BITS-2] & 1'b1);
      end
      d2_q <= d1_q;
      q2_q <= q1_q;
      z2_q <= z1_q;
    end
  end

  // stage 3: ROM read
  logic [ipt_pkg::ENTRY_W-1:0] sin_data [3];
  logic [ipt_pkg::ENTRY_W-1:0] cos_data [3];
  logic [2:0]                  sin_neg3_q, cos_neg3_q;
  logic signed [CW-1:0]        d3_q, q3_q, z3_q;

  for (genvar p = 0; p < 3; p++) begin : g_rom
    ipt_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
      .clk_i      (clk_i),
      .rd_en_i    (en3),
      .sin_addr_i (sin_addr_q[p]),
      .cos_addr_i (cos_addr_q[p]),
      .sin_data_o (sin_data[p]),
      .cos_data_o (cos_data[p])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sin_neg3_q <= sin_neg_q;
      cos_neg3_q <= cos_neg_q;
      d3_q       <= d2_q;
      q3_q       <= q2_q;
      z3_q       <= z2_q;
    end
  end

  // stage 4: c*d and s*q
  logic signed [CW-1:0] sin_val [3];
  logic signed [CW-1:0] cos_val [3];
  logic signed [PW-1:0] cd_q [3];
  logic signed [PW-1:0] sq_q [3];
  logic signed [CW-1:0] z4_q;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      sin_val[p] = sin_neg3_q[p] ? -signed'({1'b0, sin_data[p]}) : signed'({1'b0, sin_data[p]});
      cos_val[p] = cos_neg3_q[p] ? -signed'({1'b0, cos_data[p]}) : signed'({1'b0, cos_data[p]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int p = 0; p < 3; p++) begin
        cd_q[p] <= cos_val[p] * d3_q;
        sq_q[p] <= sin_val[p] * q3_q;
      end
      z4_q <= z3_q;
    end
  end

  // stage 5: round the Q15 products back to the component scale and add the zero-sequence part
  logic signed [DW-1:0] diff [3];
  logic signed [OW-1:0] res  [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      diff[p] = DW'(cd_q[p]) - DW'(sq_q[p]) + ipt_pkg::ROUND_HALF;
      res[p]  = OW'(diff[p] >>> ipt_pkg::FRAC_SH) + OW'(z4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      phase_a_o <= res[0];
      phase_b_o <= res[1];
      phase_c_o <= res[2];
    end
  end

  a_drain_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled with a bubble in the pipeline");

  a_rom_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en3) |=> (v3_q && $stable(sin_neg3_q) && $stable(cos_neg3_q)))
    else $error("ROM stage changed while held");

  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (sin_addr_q[0] <= TopIdx && cos_addr_q[0] <= TopIdx))
    else $error("ROM address beyond table");

endmodule
